[design/lzwd_pkg.sv]
// Shared types and constants of the LZW decoder.
package lzwd_pkg;

	localparam int LITERALS   = 256;
	localparam int PACK_BYTES = 8;

	typedef struct packed {
		logic [7:0] comp_byte;
		logic       chunk_last;
	} in_item_t;

	typedef struct packed {
		logic [63:0] out_bytes;
		logic [3:0]  byte_count;
		logic        run_last;
		logic        string_truncated;
	} out_item_t;

	// Tag of one queued request from the unpacker.
	typedef struct packed {
		logic has_code;
		logic last;
	} q_flags_t;

endpackage

[design/lzwd_stream_if.sv]
// Valid/ready stream channel with a typed payload.
interface lzwd_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/lzwd_front.sv]
// Bit unpacker: shifts bytes in MSB first and cuts off codes.
module lzwd_front #(
	parameter int CODE_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	lzwd_stream_if.sink             comp_in,
	input  logic                    full,
	output logic                    push,
	output lzwd_pkg::q_flags_t      flags,
	output logic [CODE_BITS-1:0]    code
);

	localparam int BUF_W  = CODE_BITS + 7;
	localparam int WIDE_W = BUF_W + 8;
	localparam int HELD_W = $clog2(CODE_BITS + 8);

	logic [BUF_W-1:0]  buf_q;
	logic [HELD_W-1:0] held_q;
	logic [WIDE_W-1:0] wide, shifted, mask;
	logic [HELD_W-1:0] held_sum, shift, rem_held;
	logic              take, accept;

	assign comp_in.ready = !full;
	assign accept        = comp_in.valid && !full;

	always_comb begin
		wide     = {buf_q, comp_in.data.comp_byte};
		held_sum = held_q + HELD_W'(8);
		take     = held_sum >= HELD_W'(CODE_BITS);
		shift    = held_sum - HELD_W'(CODE_BITS);
		shifted  = wide >> shift;
		rem_held = take ? shift : held_sum;
		mask     = (WIDE_W'(1) << rem_held) - WIDE_W'(1);
	end

	assign code           = shifted[CODE_BITS-1:0];
	assign flags.has_code = take;
	assign flags.last     = comp_in.data.chunk_last;
	assign push           = accept && (take || comp_in.data.chunk_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			held_q <= '0;
		end else if (accept) begin
			if (comp_in.data.chunk_last) begin
				buf_q  <= '0;
				held_q <= '0;
			end else begin
				buf_q  <= BUF_W'(wide & mask);
				held_q <= rem_held;
			end
		end
	end

endmodule

[design/lzwd_fifo.sv]
// Short request queue between unpacker and decoder.
module lzwd_fifo #(
	parameter int W     = 14,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wr_data,
	input  logic         pop,
	output logic [W-1:0] rd_data,
	output logic         full,
	output logic         empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

[design/lzwd_back.sv]
// Dictionary decoder: chain walk into a reverse stack, then packed output.
module lzwd_back #(
	parameter int CODE_BITS  = 12,
	parameter int MAX_STRING = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  empty,
	input  lzwd_pkg::q_flags_t    flags,
	input  logic [CODE_BITS-1:0]  code,
	output logic                  pop,
	lzwd_stream_if.source         dec_out
);

	localparam int SP_W   = (MAX_STRING > 1) ? $clog2(MAX_STRING) : 1;
	localparam int KEPT_W = $clog2(MAX_STRING + 1);
	localparam int CNT_W  = CODE_BITS + 1;
	localparam int NFC_W  = CODE_BITS + 1;
	localparam int TBL    = 1 << CODE_BITS;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_WALK  = 8'b0000_0010,
		ST_WDATA = 8'b0000_0100,
		ST_ADD   = 8'b0000_1000,
		ST_SETUP = 8'b0001_0000,
		ST_POP   = 8'b0010_0000,
		ST_PACK  = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t                  state_q;
	logic [CODE_BITS+7:0]    dict_mem [TBL];
	logic [7:0]              stack_mem [MAX_STRING];
	logic [CODE_BITS+7:0]    dict_rd_q;
	logic [7:0]              stk_rd_q;

	logic [CODE_BITS-1:0]    code_q, c_q, prev_q;
	logic                    last_q, special_q, await_q, trunc_q;
	logic [7:0]              first_q, pfb_q;
	logic [SP_W-1:0]         sp_q, r_q;
	logic [CNT_W-1:0]        pushed_q;
	logic [NFC_W-1:0]        nfc_q;
	logic [KEPT_W-1:0]       kept_q, k_q;
	logic [3:0]              n_q;
	logic [63:0]             word_q;
	logic                    out_valid_q;
	lzwd_pkg::out_item_t     out_q;

	logic                    push_en, dict_we, room, can_load, done;
	logic [SP_W-1:0]         push_addr, sp_nx;
	logic [7:0]              push_byte;
	logic [KEPT_W-1:0]       k_nx;

	assign dec_out.valid = out_valid_q;
	assign dec_out.data  = out_q;
	assign pop           = (state_q == ST_IDLE) && !empty;
	assign room          = !nfc_q[CODE_BITS];
	assign dict_we       = (state_q == ST_ADD) && room;
	assign can_load      = !out_valid_q || dec_out.ready;
	assign done          = k_q == kept_q;
	assign k_nx          = k_q + 1'b1;

	// One stack write a cycle; a new string starts at entry zero.
	always_comb begin
		push_en   = 1'b0;
		push_byte = c_q[7:0];
		push_addr = sp_q;
		unique case (state_q)
			ST_IDLE: begin
				push_addr = '0;
				if (pop && flags.has_code) begin
					if (await_q) begin
						push_en   = 1'b1;
						push_byte = code[7:0];
					end else if ({1'b0, code} >= nfc_q) begin
						push_en   = 1'b1;
						push_byte = pfb_q;
					end
				end
			end
			ST_WALK:  push_en = c_q < CODE_BITS'(lzwd_pkg::LITERALS);
			ST_WDATA: begin
				push_en   = 1'b1;
				push_byte = dict_rd_q[7:0];
			end
			default: push_en = 1'b0;
		endcase
		sp_nx = (push_addr == SP_W'(MAX_STRING - 1)) ? '0 : push_addr + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (dict_we) dict_mem[nfc_q[CODE_BITS-1:0]] <= {prev_q, first_q};
		dict_rd_q <= dict_mem[c_q];
	end

	always_ff @(posedge clk) begin
		if (push_en) stack_mem[push_addr] <= push_byte;
		stk_rd_q <= stack_mem[r_q];
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (pop) code_q <= code;
		if (pop) last_q <= flags.last;
		if (push_en) sp_q <= sp_nx;
		else if (pop) sp_q <= '0;
		unique case (state_q)
			ST_IDLE: begin
				special_q <= {1'b0, code} >= nfc_q;
				c_q       <= ({1'b0, code} >= nfc_q) ? prev_q : code;
				pushed_q  <= CNT_W'(push_en);
			end
			ST_WALK: begin
				if (push_en) begin
					first_q  <= c_q[7:0];
					pushed_q <= pushed_q + 1'b1;
				end
			end
			ST_WDATA: begin
				c_q      <= dict_rd_q[CODE_BITS+7:8];
				pushed_q <= pushed_q + 1'b1;
			end
			ST_SETUP: begin
				trunc_q <= pushed_q > CNT_W'(MAX_STRING);
				kept_q  <= (pushed_q > CNT_W'(MAX_STRING)) ? KEPT_W'(MAX_STRING)
				                                           : pushed_q[KEPT_W-1:0];
				r_q     <= (sp_q == '0) ? SP_W'(MAX_STRING - 1) : sp_q - 1'b1;
				k_q     <= '0;
				n_q     <= '0;
				word_q  <= '0;
			end
			ST_POP: begin
				k_q <= k_nx;
				r_q <= (r_q == '0) ? SP_W'(MAX_STRING - 1) : r_q - 1'b1;
			end
			ST_PACK: begin
				word_q[n_q[2:0]*8 +: 8] <= stk_rd_q;
				n_q <= n_q + 1'b1;
			end
			ST_OUT: begin
				if (can_load) begin
					out_q.out_bytes        <= word_q;
					out_q.byte_count       <= n_q;
					out_q.run_last         <= done;
					out_q.string_truncated <= trunc_q;
					word_q <= '0;
					n_q    <= '0;
				end
			end
			default: ;
		endcase
	end

	// Control state and dictionary bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nfc_q       <= NFC_W'(lzwd_pkg::LITERALS);
			prev_q      <= '0;
			pfb_q       <= '0;
			await_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && can_load) out_valid_q <= 1'b1;
			else if (dec_out.ready)            out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (!flags.has_code) begin
							if (flags.last) begin
								nfc_q   <= NFC_W'(lzwd_pkg::LITERALS);
								prev_q  <= '0;
								pfb_q   <= '0;
								await_q <= 1'b1;
							end
						end else if (await_q) begin
							prev_q  <= CODE_BITS'(code[7:0]);
							pfb_q   <= code[7:0];
							await_q <= 1'b0;
							state_q <= ST_SETUP;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK:  state_q <= push_en ? ST_ADD : ST_WDATA;
				ST_WDATA: state_q <= ST_WALK;
				ST_ADD: begin
					if (room) begin
						nfc_q  <= nfc_q + 1'b1;
						prev_q <= special_q ? nfc_q[CODE_BITS-1:0] : code_q;
					end else if (!special_q) begin
						prev_q <= code_q;
					end
					pfb_q   <= first_q;
					state_q <= ST_SETUP;
				end
				ST_SETUP: state_q <= ST_POP;
				ST_POP:   state_q <= ST_PACK;
				ST_PACK:  state_q <= (n_q == 4'(lzwd_pkg::PACK_BYTES - 1) || done)
				                     ? ST_OUT : ST_POP;
				ST_OUT: begin
					if (can_load) begin
						if (done) begin
							if (last_q) begin
								nfc_q   <= NFC_W'(lzwd_pkg::LITERALS);
								prev_q  <= '0;
								pfb_q   <= '0;
								await_q <= 1'b1;
							end
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_POP;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[design/lzw_decoder_12bit_core.sv]
// Top level of the chunked LZW decoder: unpacker, request queue, decoder.
//
// Compressed bytes enter one per cycle on comp_in while the request queue
// has room; every byte that completes a CODE_BITS code, or that ends a
// chunk, leaves a request in the queue. The decoder takes one request at a
// time. It then walks the code's prefix chain through the dictionary
// memory, one table entry at a time (registered read, then a stack push),
// pushes the closing literal, updates the table and sets up the output,
// and pops the reverse stack one byte at a time (read, then pack),
// handing out up to eight bytes per result through an output register.
// The first code of a chunk skips the walk and the table update. A
// waiting result that is not taken holds the decoder for as long as it
// waits. A chunk-end request with no code is handled as it is taken, and a
// byte that completes no code costs the decoder nothing. The dictionary
// resets at once after the last request of a chunk, so no clearing pass
// is needed.
module lzw_decoder_12bit_core #(
	parameter int CODE_BITS  = 12,
	parameter int MAX_STRING = 512
) (
	input logic           clk,
	input logic           arst_n,
	lzwd_stream_if.sink   comp_in,
	lzwd_stream_if.source dec_out
);

	localparam int QW = CODE_BITS + 2;

	logic                   f_push, q_full, q_empty, q_pop;
	lzwd_pkg::q_flags_t     f_flags, q_flags;
	logic [CODE_BITS-1:0]   f_code, q_code;
	logic [QW-1:0]          q_rd;

	lzwd_front #(.CODE_BITS(CODE_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.comp_in (comp_in),
		.full    (q_full),
		.push    (f_push),
		.flags   (f_flags),
		.code    (f_code)
	);

	// Requests: {has_code, last, code}.
	lzwd_fifo #(.W(QW), .DEPTH(4)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (f_push),
		.wr_data ({f_flags, f_code}),
		.pop     (q_pop),
		.rd_data (q_rd),
		.full    (q_full),
		.empty   (q_empty)
	);

	assign q_flags = q_rd[QW-1:CODE_BITS];
	assign q_code  = q_rd[CODE_BITS-1:0];

	lzwd_back #(.CODE_BITS(CODE_BITS), .MAX_STRING(MAX_STRING)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (q_empty),
		.flags   (q_flags),
		.code    (q_code),
		.pop     (q_pop),
		.dec_out (dec_out)
	);

endmodule
